// ===== rtl/bmprc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmprc_pkg;

	localparam int MAX_WIDTH       = 1024;
	localparam int PALETTE_ENTRIES = 256;
	localparam int QUEUE_DEPTH     = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_FORMAT = 3'd0,
		REG_COLOR_MODE   = 3'd1,
		REG_DRAW_WIDTH   = 3'd2,
		REG_DRAW_HEIGHT  = 3'd3,
		REG_ROW_BYTES    = 3'd4,
		REG_BOTTOM_UP    = 3'd5,
		REG_ORIGIN_X     = 3'd6,
		REG_ORIGIN_Y     = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FMT_1BPP  = 3'd0,
		FMT_4BPP  = 3'd1,
		FMT_8BPP  = 3'd2,
		FMT_555   = 3'd3,
		FMT_565   = 3'd4,
		FMT_24BPP = 3'd5
	} fmt_t;

	typedef enum logic [1:0] {
		MODE_MONO  = 2'd0,
		MODE_CLASS = 2'd1,
		MODE_KEEP  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_WHITE   = 2'd0,
		KIND_BLACK   = 2'd1,
		KIND_COLORED = 2'd2,
		KIND_KEPT    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		Q_PAL    = 2'd0,
		Q_INDEX  = 2'd1,
		Q_DIRECT = 2'd2
	} qop_t;

	typedef struct packed {
		logic [2:0]  pixel_format;
		logic [1:0]  color_mode;
		logic [10:0] draw_width;
		logic [10:0] draw_height;
		logic [12:0] row_bytes;
		logic        bottom_up;
		logic [9:0]  origin_x;
		logic [9:0]  origin_y;
	} cfg_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
		logic [7:0] pal_index;
		logic [7:0] pal_red;
		logic [7:0] pal_green;
		logic [7:0] pal_blue;
	} in_t;

	typedef struct packed {
		logic [1:0]  color_kind;
		logic [15:0] rgb565;
		logic [10:0] screen_x;
		logic [10:0] screen_y;
		logic        last;
	} out_t;

	// palette entry / direct pixel: bit 17 colored, bit 16 white, 15:0 RGB565
	typedef struct packed {
		qop_t        op;
		logic [17:0] entry;
		logic [7:0]  pal_idx;
		logic [7:0]  data_byte;
		logic [2:0]  fmt;
		logic [3:0]  count;
		logic [10:0] x_base;
		logic [10:0] y;
	} qent_t;

	function automatic logic with_color(input cfg_t c);
		logic wc;
		wc = (c.color_mode == MODE_CLASS) || (c.color_mode == MODE_KEEP);
		if (c.pixel_format == FMT_1BPP) begin
			wc = 1'b0;
		end
		return wc;
	endfunction

	function automatic logic [17:0] class_entry(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic wc);
		logic       white;
		logic       colored;
		logic [9:0] sum;
		sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
		if (wc) begin
			white = (r > 8'h80) && (g > 8'h80) && (b > 8'h80);
		end else begin
			white = sum > 10'd384;
		end
		colored = (r > 8'hF0) || ((g > 8'hF0) && (b > 8'hF0));
		return {colored, white, r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bmprc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmprc_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  bmprc_pkg::cfg_t      cfg,
	input  wire                  take,
	input  bmprc_pkg::in_t       item,
	output logic                 push,
	output bmprc_pkg::qent_t     push_word
);

	localparam logic [12:0] MaxW = 13'(bmprc_pkg::MAX_WIDTH);

	logic [15:0] held_q;
	logic [1:0]  held_cnt_q;
	logic [11:0] bir_q;
	logic [10:0] col_q;
	logic [10:0] row_q;

	logic [12:0] effw;
	logic [12:0] room;
	logic        row_in;
	logic        is_index;
	logic [3:0]  k;
	logic [3:0]  m;
	logic        complete;
	logic [7:0]  lsb;
	logic [7:0]  msb;
	logic [7:0]  r;
	logic [7:0]  g;
	logic [7:0]  bl;
	logic [17:0] dir_entry;
	logic [11:0] col_sum;
	logic [10:0] col_step;
	logic [10:0] row_v;
	logic        row_end;
	logic        wc;

	assign wc = bmprc_pkg::with_color(cfg);

	always_comb begin
		effw = ({2'b00, cfg.draw_width} < MaxW) ? {2'b00, cfg.draw_width} : MaxW;
		row_in = row_q < cfg.draw_height;
		room = (effw > {2'b00, col_q}) ? (effw - {2'b00, col_q}) : 13'd0;

		is_index = 1'b0;
		case (cfg.pixel_format)
			bmprc_pkg::FMT_1BPP: begin is_index = 1'b1; k = 4'd8; end
			bmprc_pkg::FMT_4BPP: begin is_index = 1'b1; k = 4'd2; end
			bmprc_pkg::FMT_8BPP: begin is_index = 1'b1; k = 4'd1; end
			default:             k = 4'd1;
		endcase

		m = (room < {9'd0, k}) ? room[3:0] : k;
		if (!row_in) begin
			m = 4'd0;
		end

		if ((cfg.pixel_format == bmprc_pkg::FMT_555) ||
				(cfg.pixel_format == bmprc_pkg::FMT_565)) begin
			complete = held_cnt_q >= 2'd1;
		end else begin
			complete = held_cnt_q >= 2'd2;
		end

		lsb = held_q[7:0];
		msb = item.data_byte;
		bl  = {lsb[4:0], 3'b000};
		case (cfg.pixel_format)
			bmprc_pkg::FMT_555: begin
				g = {msb[1:0], lsb[7:5], 3'b000};
				r = {msb[6:2], 3'b000};
			end
			bmprc_pkg::FMT_565: begin
				g = {msb[2:0], lsb[7:5], 2'b00};
				r = {msb[7:3], 3'b000};
			end
			default: begin
				bl = held_q[7:0];
				g  = held_q[15:8];
				r  = item.data_byte;
			end
		endcase
		dir_entry = bmprc_pkg::class_entry(r, g, bl, wc);

		col_sum  = {1'b0, col_q} + {8'd0, k};
		col_step = (col_sum > 12'h7FF) ? 11'h7FF : col_sum[10:0];

		row_v = cfg.bottom_up ? (cfg.draw_height - row_q - 11'd1) : row_q;

		row_end = (({1'b0, bir_q} + 13'd1) >= cfg.row_bytes) || (bir_q == 12'hFFF);
	end

	// build the queue word
	always_comb begin
		push_word.op        = bmprc_pkg::Q_INDEX;
		push_word.entry     = dir_entry;
		push_word.pal_idx   = item.pal_index;
		push_word.data_byte = item.data_byte;
		push_word.fmt       = cfg.pixel_format;
		push_word.count     = m;
		push_word.x_base    = 11'({1'b0, cfg.origin_x} + col_q);
		push_word.y         = 11'({1'b0, cfg.origin_y} + row_v);
		push = 1'b0;
		if (take) begin
			if (!item.op) begin
				push_word.op    = bmprc_pkg::Q_PAL;
				push_word.entry = bmprc_pkg::class_entry(item.pal_red, item.pal_green,
						item.pal_blue, wc);
				push = 1'b1;
			end else if (is_index) begin
				push = m != 4'd0;
			end else begin
				push_word.op    = bmprc_pkg::Q_DIRECT;
				push_word.count = 4'd1;
				push = complete && row_in && ({2'b00, col_q} < effw);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_cnt_q <= '0;
			bir_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (take && item.op) begin
			if (is_index) begin
				col_q <= col_step;
			end else if (complete) begin
				held_q     <= '0;
				held_cnt_q <= '0;
				col_q      <= col_step;
			end else begin
				if (held_cnt_q == 2'd0) begin
					held_q[7:0] <= held_q[7:0] | item.data_byte;
				end else begin
					held_q[15:8] <= held_q[15:8] | item.data_byte;
				end
				held_cnt_q <= held_cnt_q + 2'd1;
			end
			if (row_end) begin
				bir_q      <= '0;
				col_q      <= '0;
				held_q     <= '0;
				held_cnt_q <= '0;
				if (({1'b0, row_q} + 12'd1) >= {1'b0, cfg.draw_height}) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 11'd1;
				end
			end else begin
				bir_q <= bir_q + 12'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bmprc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmprc_fifo #(
	parameter int DEPTH = bmprc_pkg::QUEUE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  bmprc_pkg::qent_t     push_word,
	input  wire                  pop,
	output logic                 full,
	output logic                 head_valid,
	output bmprc_pkg::qent_t     head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
	localparam logic [CW-1:0] Full    = CW'(DEPTH);

	bmprc_pkg::qent_t slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full       = count_q == Full;
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/bmprc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmprc_back #(
	parameter int PALETTE_ENTRIES = bmprc_pkg::PALETTE_ENTRIES
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  bmprc_pkg::cfg_t      cfg,
	input  wire                  head_valid,
	input  bmprc_pkg::qent_t     head,
	output logic                 pop,
	output logic                 pix_valid,
	input  wire                  pix_stall,
	output bmprc_pkg::out_t      pix_word
);

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [8:0] NumEntries = 9'(PALETTE_ENTRIES);

	logic [17:0] pal_mem [PALETTE_ENTRIES];

	logic [2:0]  sub_q;
	logic        s2_valid_q;
	logic [17:0] rd_s2;
	logic [17:0] entry_s2;
	logic        direct_s2;
	logic        oob_s2;
	logic [10:0] x_s2;
	logic [10:0] y_s2;
	logic        last_s2;

	logic        adv;
	logic        is_pal;
	logic        issue;
	logic        last_sub;
	logic        wr_en;
	logic [7:0]  pn;
	logic        oob;
	logic [17:0] e;
	logic        wc;
	logic        keep;

	assign adv      = !s2_valid_q || !pix_stall;
	assign is_pal   = head.op == bmprc_pkg::Q_PAL;
	assign issue    = head_valid && !is_pal && adv;
	assign last_sub = ({1'b0, sub_q} + 4'd1) == head.count;
	assign wr_en    = head_valid && is_pal && ({1'b0, head.pal_idx} < NumEntries);
	assign pop      = head_valid && (is_pal || (issue && last_sub));

	// pick the index of the current sub-pixel, leftmost first
	always_comb begin
		case (head.fmt)
			bmprc_pkg::FMT_1BPP: pn = {7'd0, head.data_byte[3'd7 - sub_q]};
			bmprc_pkg::FMT_4BPP: pn = sub_q[0] ? {4'd0, head.data_byte[3:0]}
					: {4'd0, head.data_byte[7:4]};
			default:             pn = head.data_byte;
		endcase
		oob = {1'b0, pn} >= NumEntries;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pal_mem[head.pal_idx[AW-1:0]] <= head.entry;
		end
		if (issue) begin
			rd_s2 <= pal_mem[pn[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			entry_s2  <= head.entry;
			direct_s2 <= head.op == bmprc_pkg::Q_DIRECT;
			oob_s2    <= oob;
			x_s2      <= head.x_base + {8'd0, sub_q};
			y_s2      <= head.y;
			last_s2   <= last_sub;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q      <= '0;
			s2_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				s2_valid_q <= issue;
			end
			if (issue) begin
				sub_q <= last_sub ? 3'd0 : sub_q + 3'd1;
			end
		end
	end

	always_comb begin
		wc   = bmprc_pkg::with_color(cfg);
		keep = wc && (cfg.color_mode == bmprc_pkg::MODE_KEEP);
		if (direct_s2) begin
			e = entry_s2;
		end else if (oob_s2) begin
			e = '0;
		end else begin
			e = rd_s2;
		end
		if (keep) begin
			pix_word.color_kind = bmprc_pkg::KIND_KEPT;
		end else if (e[16]) begin
			pix_word.color_kind = bmprc_pkg::KIND_WHITE;
		end else if (e[17] && wc) begin
			pix_word.color_kind = bmprc_pkg::KIND_COLORED;
		end else begin
			pix_word.color_kind = bmprc_pkg::KIND_BLACK;
		end
		pix_word.rgb565   = keep ? e[15:0] : 16'd0;
		pix_word.screen_x = x_s2;
		pix_word.screen_y = y_s2;
		pix_word.last     = last_s2;
	end

	assign pix_valid = s2_valid_q;

	a_sub_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && (head.op == bmprc_pkg::Q_INDEX)) |-> ({1'b0, sub_q} < head.count))
		else $error("sub-pixel index past the word's pixel count");

	a_sub_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && last_sub) |=> (sub_q == 3'd0))
		else $error("sub-pixel index not cleared after last pixel");

endmodule

`default_nettype wire

// ===== rtl/bmp_row_pixel_classifier_core.sv =====
// Pixels pass through the queue registers and then the palette read stage before leaving.
// Bytes are taken one per cycle while the queue is not full. A 4 or 1 bpp byte stays at
// the queue head until its pixels are out; the single palette read port emits one pixel
// per cycle unless pix_stall is high; bytes stall once the QUEUE_DEPTH-entry queue fills.
// Reset (arst_n, async low) clears config to defaults, row/column state and the queue;
// palette contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module bmp_row_pixel_classifier_core #(
	parameter int PALETTE_ENTRIES = bmprc_pkg::PALETTE_ENTRIES,
	parameter int QUEUE_DEPTH     = bmprc_pkg::QUEUE_DEPTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               byte_valid,
	output logic                              byte_stall,
	input  bmprc_pkg::in_t                    byte_word,
	output logic                              pix_valid,
	input  wire                               pix_stall,
	output bmprc_pkg::out_t                   pix_word,
	input  wire                               cfg_we,
	input  wire [bmprc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire [bmprc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	bmprc_pkg::cfg_t  cfg_q;
	bmprc_pkg::qent_t push_word;
	bmprc_pkg::qent_t head;
	logic             take;
	logic             push;
	logic             pop;
	logic             full;
	logic             head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= bmprc_pkg::FMT_24BPP;
			cfg_q.color_mode   <= bmprc_pkg::MODE_MONO;
			cfg_q.draw_width   <= '0;
			cfg_q.draw_height  <= '0;
			cfg_q.row_bytes    <= '0;
			cfg_q.bottom_up    <= 1'b1;
			cfg_q.origin_x     <= '0;
			cfg_q.origin_y     <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				bmprc_pkg::REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_wdata[2:0];
				bmprc_pkg::REG_COLOR_MODE:   cfg_q.color_mode   <= cfg_wdata[1:0];
				bmprc_pkg::REG_DRAW_WIDTH:   cfg_q.draw_width   <= cfg_wdata[10:0];
				bmprc_pkg::REG_DRAW_HEIGHT:  cfg_q.draw_height  <= cfg_wdata[10:0];
				bmprc_pkg::REG_ROW_BYTES:    cfg_q.row_bytes    <= cfg_wdata[12:0];
				bmprc_pkg::REG_BOTTOM_UP:    cfg_q.bottom_up    <= cfg_wdata[0];
				bmprc_pkg::REG_ORIGIN_X:     cfg_q.origin_x     <= cfg_wdata[9:0];
				bmprc_pkg::REG_ORIGIN_Y:     cfg_q.origin_y     <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	assign byte_stall = full;
	assign take       = byte_valid && !full;

	bmprc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.take      (take),
		.item      (byte_word),
		.push      (push),
		.push_word (push_word)
	);

	bmprc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_word  (push_word),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	bmprc_back #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_word   (pix_word)
	);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import bmprc_pkg::*;

	localparam int          CLK_HALF      = 6;
	localparam int          RESET_CYCLES  = 9;
	localparam int          SETTLE_CYCLES = 100;
	localparam int          QUIET_LIMIT   = 4000;
	localparam int          RANDOM_WORDS  = 200;
	localparam int          REPORT_LIMIT  = 40;
	localparam int unsigned WHITE_LEVEL   = 'h80;
	localparam int unsigned COLOR_LEVEL   = 'hF0;
	localparam int unsigned ROW_BYTE_CAP  = 4095;
	localparam int unsigned COLUMN_CAP    = 2047;
	localparam logic        OP_PALETTE    = 1'b0;
	localparam logic        OP_PIXEL      = 1'b1;

	logic                 clk;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_stall;
	in_t                  byte_word;
	logic                 pix_valid;
	logic                 pix_stall;
	out_t                 pix_word;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bmp_row_pixel_classifier_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_word   (pix_word),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	// decoder shadow: configuration, palette and row position
	cfg_t        cfg_shadow;
	logic [17:0] palette_shadow [PALETTE_ENTRIES];
	logic [15:0] partial_bytes = '0;
	int unsigned partial_count = 0;
	int unsigned byte_pos      = 0;
	int unsigned column_pos    = 0;
	int unsigned row_pos       = 0;
	out_t        held_pixel;
	bit          held_pixel_valid = 0;

	in_t         word_plan [$];
	out_t        pixels_expected [$];
	out_t        pixel_due;
	int unsigned words_planned = 0;
	int unsigned words_taken   = 0;
	int unsigned send_gap_pct  = 0;
	int unsigned stall_pct     = 0;
	int unsigned error_count   = 0;
	int unsigned quiet_cycles  = 0;

	function automatic int unsigned bits_per_pixel(input logic [2:0] fmt);
		case (fmt)
			FMT_1BPP: return 1;
			FMT_4BPP: return 4;
			FMT_8BPP: return 8;
			FMT_555, FMT_565: return 16;
			default: return 24;
		endcase
	endfunction

	function automatic bit color_on();
		return bits_per_pixel(cfg_shadow.pixel_format) != 1 &&
			(cfg_shadow.color_mode == MODE_CLASS || cfg_shadow.color_mode == MODE_KEEP);
	endfunction

	function automatic bit reads_white(input int unsigned r, input int unsigned g,
			input int unsigned b, input bit wc);
		if (wc) begin
			return r > WHITE_LEVEL && g > WHITE_LEVEL && b > WHITE_LEVEL;
		end
		return r + g + b > 3 * WHITE_LEVEL;
	endfunction

	function automatic bit reads_colored(input int unsigned r, input int unsigned g,
			input int unsigned b);
		return r > COLOR_LEVEL || (g > COLOR_LEVEL && b > COLOR_LEVEL);
	endfunction

	function automatic logic [15:0] pack565(input int unsigned r, input int unsigned g,
			input int unsigned b);
		return 16'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | ((b & 'hF8) >> 3));
	endfunction

	// hold each pixel back one step so the final one of a byte can carry last
	function automatic void emit_pixel(input bit white, input bit colored,
			input logic [15:0] c565);
		int unsigned eff_width;
		int unsigned row_idx;
		bit          wc;
		out_t        px;
		eff_width = int'(cfg_shadow.draw_width) < MAX_WIDTH ?
			int'(cfg_shadow.draw_width) : MAX_WIDTH;
		wc = color_on();
		if (row_pos < cfg_shadow.draw_height && column_pos < eff_width) begin
			px = '0;
			if (wc && cfg_shadow.color_mode == MODE_KEEP) begin
				px.color_kind = KIND_KEPT;
				px.rgb565 = c565;
			end else if (white) begin
				px.color_kind = KIND_WHITE;
			end else if (colored && wc) begin
				px.color_kind = KIND_COLORED;
			end else begin
				px.color_kind = KIND_BLACK;
			end
			row_idx = cfg_shadow.bottom_up ? cfg_shadow.draw_height - row_pos - 1 : row_pos;
			px.screen_x = 11'(cfg_shadow.origin_x + column_pos);
			px.screen_y = 11'(cfg_shadow.origin_y + row_idx);
			if (held_pixel_valid) begin
				pixels_expected.push_back(held_pixel);
			end
			held_pixel = px;
			held_pixel_valid = 1;
		end
		if (column_pos < COLUMN_CAP) begin
			column_pos++;
		end
	endfunction

	function automatic void predict_pixels(input in_t w);
		int unsigned depth;
		int unsigned bits;
		int unsigned idx;
		int unsigned lsb;
		int unsigned msb;
		int unsigned r;
		int unsigned g;
		int unsigned b;
		logic [17:0] entry;
		logic [15:0] c565;
		bit          wc;
		depth = bits_per_pixel(cfg_shadow.pixel_format);
		wc = color_on();
		held_pixel_valid = 0;
		if (w.op == OP_PALETTE) begin
			// classify with the mode in force when the entry is written
			r = w.pal_red;
			g = w.pal_green;
			b = w.pal_blue;
			palette_shadow[w.pal_index] = {reads_colored(r, g, b), reads_white(r, g, b, wc),
				pack565(r, g, b)};
			return;
		end
		if (depth <= 8) begin
			bits = w.data_byte;
			for (int k = 0; k < 8 / depth; k++) begin
				idx = (bits >> (8 - depth)) & ((1 << depth) - 1);
				entry = palette_shadow[idx];
				bits = (bits << depth) & 'hFF;
				emit_pixel(entry[16], entry[17], entry[15:0]);
			end
		end else if (partial_count + 1 < (depth == 16 ? 2 : 3)) begin
			partial_bytes = partial_bytes | (16'(w.data_byte) << (8 * partial_count));
			partial_count++;
		end else begin
			if (depth == 24) begin
				b = partial_bytes[7:0];
				g = partial_bytes[15:8];
				r = w.data_byte;
				c565 = pack565(r, g, b);
			end else begin
				lsb = partial_bytes[7:0];
				msb = w.data_byte;
				b = (lsb & 'h1F) << 3;
				if (cfg_shadow.pixel_format == FMT_555) begin
					g = ((msb & 'h03) << 6) | ((lsb & 'hE0) >> 2);
					r = (msb & 'h7C) << 1;
					c565 = pack565(r, g, b);
				end else begin
					g = ((msb & 'h07) << 5) | ((lsb & 'hE0) >> 3);
					r = msb & 'hF8;
					c565 = 16'((msb << 8) | lsb);
				end
			end
			partial_bytes = '0;
			partial_count = 0;
			emit_pixel(reads_white(r, g, b, wc), reads_colored(r, g, b), c565);
		end
		// row end: drop any partial pixel and advance the row
		if (byte_pos + 1 >= cfg_shadow.row_bytes || byte_pos >= ROW_BYTE_CAP) begin
			byte_pos = 0;
			column_pos = 0;
			partial_bytes = '0;
			partial_count = 0;
			if (row_pos + 1 >= cfg_shadow.draw_height) begin
				row_pos = 0;
			end else begin
				row_pos++;
			end
		end else begin
			byte_pos++;
		end
		if (held_pixel_valid) begin
			held_pixel.last = 1'b1;
			pixels_expected.push_back(held_pixel);
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= REPORT_LIMIT) begin
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			end
		end
	endfunction

	function automatic in_t noise_word();
		in_t w;
		w.op        = 1'($urandom);
		w.data_byte = 8'($urandom);
		w.pal_index = 8'($urandom);
		w.pal_red   = 8'($urandom);
		w.pal_green = 8'($urandom);
		w.pal_blue  = 8'($urandom);
		return w;
	endfunction

	// lean toward the classification thresholds
	function automatic int unsigned shade();
		case ($urandom_range(5))
			0: return WHITE_LEVEL;
			1: return WHITE_LEVEL + 1;
			2: return COLOR_LEVEL;
			3: return COLOR_LEVEL + 1;
			default: return $urandom_range(255);
		endcase
	endfunction

	task automatic plan_pixel(input int unsigned data);
		in_t w;
		w = noise_word();
		w.op = OP_PIXEL;
		w.data_byte = 8'(data);
		word_plan.push_back(w);
		words_planned++;
	endtask

	task automatic plan_palette(input int unsigned idx, input int unsigned r,
			input int unsigned g, input int unsigned b);
		in_t w;
		w = noise_word();
		w.op = OP_PALETTE;
		w.pal_index = 8'(idx);
		w.pal_red = 8'(r);
		w.pal_green = 8'(g);
		w.pal_blue = 8'(b);
		word_plan.push_back(w);
		words_planned++;
	endtask

	task automatic pace(input int unsigned sel);
		case (sel)
			0: begin send_gap_pct = 0;  stall_pct = 0;  end
			1: begin send_gap_pct = 66; stall_pct = 0;  end
			2: begin send_gap_pct = 0;  stall_pct = 66; end
			default: begin send_gap_pct = 30; stall_pct = 30; end
		endcase
	endtask

	task automatic settle();
		do begin
			@(posedge clk);
		end while (words_taken != words_planned || pixels_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t which, input int unsigned data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= which;
		cfg_wdata <= data[CFG_DATA_W-1:0];
		case (which)
			REG_PIXEL_FORMAT: cfg_shadow.pixel_format = data[2:0];
			REG_COLOR_MODE:   cfg_shadow.color_mode   = data[1:0];
			REG_DRAW_WIDTH:   cfg_shadow.draw_width   = data[10:0];
			REG_DRAW_HEIGHT:  cfg_shadow.draw_height  = data[10:0];
			REG_ROW_BYTES:    cfg_shadow.row_bytes    = data[12:0];
			REG_BOTTOM_UP:    cfg_shadow.bottom_up    = data[0];
			REG_ORIGIN_X:     cfg_shadow.origin_x     = data[9:0];
			REG_ORIGIN_Y:     cfg_shadow.origin_y     = data[9:0];
			default: ;
		endcase
	endtask

	task automatic setup_image(input int unsigned fmt, input int unsigned mode,
			input int unsigned width, input int unsigned height, input int unsigned rbytes,
			input int unsigned bup, input int unsigned ox, input int unsigned oy);
		settle();
		write_reg(REG_PIXEL_FORMAT, fmt);
		write_reg(REG_COLOR_MODE, mode);
		write_reg(REG_DRAW_WIDTH, width);
		write_reg(REG_DRAW_HEIGHT, height);
		write_reg(REG_ROW_BYTES, rbytes);
		write_reg(REG_BOTTOM_UP, bup);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned pick_origin();
		case ($urandom_range(3))
			0: return 0;
			1: return 1023;
			default: return $urandom_range(1023);
		endcase
	endfunction

	task automatic random_image(input int unsigned pacing, input bit wide);
		int unsigned fmt;
		int unsigned width;
		int unsigned height;
		int unsigned rbytes;
		int unsigned count;
		fmt = $urandom_range(7);
		width = $urandom_range(12);
		height = $urandom_range(9) == 0 ? 0 : $urandom_range(1, 4);
		rbytes = ((width * bits_per_pixel(3'(fmt)) + 31) / 32) * 4;
		if (rbytes == 0 || $urandom_range(4) == 0) begin
			rbytes = $urandom_range(8);
		end
		count = $urandom_range(1, 3) * (rbytes == 0 ? 1 : rbytes);
		if (wide) begin
			width = $urandom_range(1) ? 2047 : 1024;
			height = $urandom_range(1) ? 2047 : 1024;
			rbytes = $urandom_range(1) ? 8191 : 4096;
			count = $urandom_range(10, 20);
		end
		if (count > 48) begin
			count = 48;
		end
		// break the row now and then
		if ($urandom_range(3) == 0) begin
			count += $urandom_range(1, 3);
		end
		setup_image(fmt, $urandom_range(3), width, height, rbytes, $urandom_range(1),
			pick_origin(), pick_origin());
		pace(pacing);
		repeat (count) begin
			if ($urandom_range(9) == 0) begin
				plan_palette($urandom_range(255), shade(), shade(), shade());
			end else begin
				plan_pixel($urandom_range(1) ? shade() : $urandom_range(255));
			end
		end
	endtask

	// driver: present the next planned word, hold it while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_word <= '0;
		end else begin
			if (byte_valid && !byte_stall) begin
				predict_pixels(byte_word);
				words_taken++;
			end
			if (!byte_valid || !byte_stall) begin
				if (word_plan.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					byte_word <= word_plan.pop_front();
					byte_valid <= 1'b1;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each pixel word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_stall <= 1'b0;
		end else begin
			if (pix_valid && !pix_stall) begin
				if (pixels_expected.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT) begin
						$display("%0t: expected no pixel word, got %h", $time, pix_word);
					end
				end else begin
					pixel_due = pixels_expected.pop_front();
					check_field("color_kind", 16'(pixel_due.color_kind), 16'(pix_word.color_kind));
					check_field("rgb565", pixel_due.rgb565, pix_word.rgb565);
					check_field("screen_x", 16'(pixel_due.screen_x), 16'(pix_word.screen_x));
					check_field("screen_y", 16'(pixel_due.screen_y), 16'(pix_word.screen_y));
					check_field("last", 16'(pixel_due.last), 16'(pix_word.last));
				end
			end
			pix_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (pix_valid && !pix_stall) ||
				(words_taken == words_planned && pixels_expected.size() == 0)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		int unsigned start_words;
		int unsigned phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		cfg_shadow = '0;
		cfg_shadow.pixel_format = FMT_24BPP;
		cfg_shadow.color_mode = MODE_MONO;
		cfg_shadow.bottom_up = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// fill the whole palette so no pixel reads an unwritten entry
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			plan_palette(i, $urandom_range(255), $urandom_range(255), $urandom_range(255));
		end

		// one bit per pixel forces monochrome even in keep mode
		setup_image(FMT_1BPP, MODE_KEEP, 8, 2, 4, 1, 0, 0);
		plan_palette(0, 'h80, 'h80, 'h80);
		plan_palette(1, 'hFF, 'hFF, 'hFF);
		plan_pixel('hA5);
		plan_pixel('hFF);
		plan_pixel('h00);
		plan_pixel('h5A);
		// two BGR pixels, then a lone byte dropped at the row end
		setup_image(FMT_24BPP, MODE_CLASS, 2, 2, 7, 0, 1023, 1023);
		plan_pixel('h00);
		plan_pixel('h00);
		plan_pixel('hFF);
		plan_pixel('hFF);
		plan_pixel('hFF);
		plan_pixel('hFF);
		plan_pixel('h81);
		// zero height draws nothing
		setup_image(FMT_565, MODE_KEEP, 2047, 0, 2, 1, 0, 0);
		plan_pixel('hFF);
		plan_pixel('hFF);
		// undefined format and mode, widest height, row bytes and origins
		setup_image(7, 3, 1, 2047, 8191, 1, 1023, 1023);
		plan_pixel('h80);
		plan_pixel('h80);
		plan_pixel('h81);
		// zero row bytes ends every row after one byte
		setup_image(FMT_555, MODE_CLASS, 1, 1, 0, 0, 5, 5);
		plan_pixel('h1F);
		plan_pixel('hFF);
		setup_image(FMT_4BPP, MODE_KEEP, 3, 1, 4, 1, 100, 200);
		plan_pixel('hF0);
		plan_pixel('h0E);
		setup_image(FMT_8BPP, MODE_CLASS, 4, 1, 4, 0, 0, 1023);
		plan_pixel('h00);
		plan_pixel('hFF);

		start_words = words_planned;
		phase = 0;
		while (words_planned - start_words < RANDOM_WORDS) begin
			random_image(phase % 4, phase % 7 == 6);
			phase++;
		end

		// a full row past the width limit at one bit per pixel
		setup_image(FMT_1BPP, MODE_CLASS, 1100, 2, 140, 0, 1023, 7);
		pace(3);
		repeat (140) plan_pixel($urandom_range(255));

		settle();
		if (error_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
